/* rtl/core/twdm_pkg.sv */
// ----------------------------------------------------------------------------
// twdm_pkg
// Shared types and constants of the twist to wheel duty mixer: register
// indexes, motion kinds, divider lane and stage records, and the duty clamp.
// ----------------------------------------------------------------------------
package twdm_pkg;

   // Divider geometry: numerator 2*|n| + d, divisor 2*d
   localparam int NUM_W       = 17;
   localparam int DEN_W       = 16;
   localparam int QUO_W       = NUM_W;
   localparam int DIV_STAGES  = QUO_W;
   localparam int MIX_STAGES  = 4;
   localparam int PIPE_STAGES = 1 + DIV_STAGES + MIX_STAGES;

   // Register indexes on the csr port
   localparam logic [2:0] CSR_BASE_SPEED     = 3'd0;
   localparam logic [2:0] CSR_SPEED_STEP     = 3'd1;
   localparam logic [2:0] CSR_BASE_DUTY      = 3'd2;
   localparam logic [2:0] CSR_DUTY_STEP      = 3'd3;
   localparam logic [2:0] CSR_MAX_DUTY       = 3'd4;
   localparam logic [2:0] CSR_MIN_DUTY       = 3'd5;
   localparam logic [2:0] CSR_BASE_TURN_DIFF = 3'd6;

   // Register reset values
   localparam logic [14:0] RST_BASE_SPEED     = 15'd600;
   localparam logic [14:0] RST_SPEED_STEP     = 15'd100;
   localparam logic [9:0]  RST_BASE_DUTY      = 10'd600;
   localparam logic [9:0]  RST_DUTY_STEP      = 10'd100;
   localparam logic [9:0]  RST_MAX_DUTY       = 10'd1000;
   localparam logic [9:0]  RST_MIN_DUTY       = 10'd600;
   localparam logic [9:0]  RST_BASE_TURN_DIFF = 10'd200;

   typedef enum logic [3:0] {
      KIND_STOP       = 4'd0,
      KIND_FWD        = 4'd1,
      KIND_BACK       = 4'd2,
      KIND_LEFT       = 4'd3,
      KIND_RIGHT      = 4'd4,
      KIND_FWD_LEFT   = 4'd5,
      KIND_FWD_RIGHT  = 4'd6,
      KIND_BACK_LEFT  = 4'd7,
      KIND_BACK_RIGHT = 4'd8
   } twdm_kind_type;

   // Duty-side registers used by the mixing stages
   typedef struct packed {
      logic [9:0] base_duty;
      logic [9:0] duty_step;
      logic [9:0] max_duty;
      logic [9:0] min_duty;
      logic [9:0] base_turn_diff;
   } twdm_cfg_type;

   // Sign and zero flags that ride along with an item
   typedef struct packed {
      logic lin_zero;
      logic lin_neg;
      logic ang_zero;
      logic ang_neg;
      logic lin_nneg;   // |linear| below base speed
      logic ang_nneg;   // |angular| below base speed
   } twdm_tag_type;

   // One lane of the restoring divider
   typedef struct packed {
      logic [DEN_W-1:0] rem;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
      logic [QUO_W-1:0] quo;
   } twdm_lane_type;

   typedef struct packed {
      twdm_lane_type lin;
      twdm_lane_type ang;
      twdm_tag_type  tag;
   } twdm_div_stage_type;

   // clamp(x) = max(min(x, hi), lo)
   function automatic logic [9:0] twdm_clamp(input logic signed [30:0] x,
                                             input logic [9:0] hi,
                                             input logic [9:0] lo);
      logic signed [30:0] hi_x;
      logic signed [30:0] lo_x;
      logic signed [30:0] t;
      hi_x = $signed({21'd0, hi});
      lo_x = $signed({21'd0, lo});
      t    = (x > hi_x) ? hi_x : x;
      return (t < lo_x) ? lo : t[9:0];
   endfunction

endpackage

/* rtl/core/twist_to_wheel_duty_mixer_unit.sv */
// ----------------------------------------------------------------------------
// twist_to_wheel_duty_mixer_unit
// Turns a linear/angular speed command into left and right wheel duties.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-----------------------------
//   req     | in        | req_valid / req_stall | linear_speed, angular_speed
//   rsp     | out       | rsp_valid / rsp_stall | left/right duty, kind, adj
//   csr     | in        | csr_write_enable      | csr_index, csr_data
//
// One item per cycle while rsp_stall is low. Stages: one setup stage, 17 divider
// stages (one quotient bit each, the step quantization) and four mixing stages.
// Synchronous active-high reset clears the stage valid bits and loads the
// register defaults. A stalled result holds in the output stage while
// earlier stages keep closing up bubbles; req_stall rises only when every
// stage is full.
// ----------------------------------------------------------------------------
module twist_to_wheel_duty_mixer_unit (
   input  logic               clock,
   input  logic               reset,
   // input channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_linear_speed,
   input  logic signed [15:0] req_angular_speed,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [10:0] rsp_left_duty,
   output logic signed [10:0] rsp_right_duty,
   output logic [3:0]         rsp_motion_kind,
   output logic               rsp_max_adjusted,
   // configuration
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [14:0]        csr_data
);
   import twdm_pkg::*;

   // ---- configuration registers
   logic [14:0] base_speed_ff, speed_step_ff;
   logic [9:0]  base_duty_ff, duty_step_ff, max_duty_ff, min_duty_ff, base_turn_diff_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_speed_ff     <= RST_BASE_SPEED;
         speed_step_ff     <= RST_SPEED_STEP;
         base_duty_ff      <= RST_BASE_DUTY;
         duty_step_ff      <= RST_DUTY_STEP;
         max_duty_ff       <= RST_MAX_DUTY;
         min_duty_ff       <= RST_MIN_DUTY;
         base_turn_diff_ff <= RST_BASE_TURN_DIFF;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_BASE_SPEED:     base_speed_ff     <= csr_data;
            CSR_SPEED_STEP:     speed_step_ff     <= csr_data;
            CSR_BASE_DUTY:      base_duty_ff      <= csr_data[9:0];
            CSR_DUTY_STEP:      duty_step_ff      <= csr_data[9:0];
            CSR_MAX_DUTY:       max_duty_ff       <= csr_data[9:0];
            CSR_MIN_DUTY:       min_duty_ff       <= csr_data[9:0];
            CSR_BASE_TURN_DIFF: base_turn_diff_ff <= csr_data[9:0];
            default: begin
            end
         endcase
      end
   end

   twdm_cfg_type cfg;
   assign cfg = '{base_duty:      base_duty_ff,
                  duty_step:      duty_step_ff,
                  max_duty:       max_duty_ff,
                  min_duty:       min_duty_ff,
                  base_turn_diff: base_turn_diff_ff};

   // ---- stage valid bits and per-stage enables
   // A stage loads when it is empty or its content moves on.
   logic [PIPE_STAGES-1:0] valid_ff;
   logic [PIPE_STAGES-1:0] en;

   assign en[PIPE_STAGES-1] = !valid_ff[PIPE_STAGES-1] || !rsp_stall;
   for (genvar i = 0; i < PIPE_STAGES - 1; i++) begin : g_en
      assign en[i] = !valid_ff[i] || en[i+1];
   end

   for (genvar i = 0; i < PIPE_STAGES; i++) begin : g_valid
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en[i]) begin
            valid_ff[i] <= (i == 0) ? req_valid : valid_ff[(i == 0) ? 0 : i-1];
         end
      end
   end

   assign req_stall = !en[0];
   assign rsp_valid = valid_ff[PIPE_STAGES-1];

   // ---- setup stage: divider operands for round-half-away quantization
   // steps = (2*|n| + d) / (2*d), n = |v| - base_speed
   logic [14:0]        step_d;
   logic signed [16:0] lin_x, ang_x;
   logic [16:0]        lin_abs, ang_abs;
   logic signed [17:0] lin_n, ang_n;
   logic [15:0]        lin_m, ang_m;
   logic [17:0]        lin_nn, ang_nn;
   logic [NUM_W-1:0]   lin_num_in, ang_num_in, lin_num_ff, ang_num_ff;
   logic [DEN_W-1:0]   den_in, den_ff;
   twdm_tag_type       tag_in, tag0_ff;

   always_comb begin
      step_d     = (speed_step_ff == '0) ? 15'd1 : speed_step_ff;
      lin_x      = 17'(req_linear_speed);
      ang_x      = 17'(req_angular_speed);
      lin_abs    = lin_x[16] ? 17'(17'sd0 - lin_x) : 17'(lin_x);
      ang_abs    = ang_x[16] ? 17'(17'sd0 - ang_x) : 17'(ang_x);
      lin_n      = $signed({1'b0, lin_abs}) - $signed({3'b000, base_speed_ff});
      ang_n      = $signed({1'b0, ang_abs}) - $signed({3'b000, base_speed_ff});
      lin_nn     = 18'd0 - lin_n;
      ang_nn     = 18'd0 - ang_n;
      lin_m      = lin_n[17] ? lin_nn[15:0] : lin_n[15:0];
      ang_m      = ang_n[17] ? ang_nn[15:0] : ang_n[15:0];
      lin_num_in = {lin_m, 1'b0} + NUM_W'(step_d);
      ang_num_in = {ang_m, 1'b0} + NUM_W'(step_d);
      den_in     = {step_d, 1'b0};

      tag_in.lin_zero = (req_linear_speed == '0);
      tag_in.lin_neg  = req_linear_speed[15];
      tag_in.ang_zero = (req_angular_speed == '0);
      tag_in.ang_neg  = req_angular_speed[15];
      tag_in.lin_nneg = lin_n[17];
      tag_in.ang_nneg = ang_n[17];
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         lin_num_ff <= lin_num_in;
         ang_num_ff <= ang_num_in;
         den_ff     <= den_in;
         tag0_ff    <= tag_in;
      end
   end

   // ---- step quantization divider
   logic [QUO_W-1:0] lin_quo, ang_quo;
   twdm_tag_type     tag_div;

   twdm_div u_div (
      .clock   (clock),
      .en      (en[DIV_STAGES:1]),
      .lin_num (lin_num_ff),
      .lin_den (den_ff),
      .ang_num (ang_num_ff),
      .ang_den (den_ff),
      .tag_in  (tag0_ff),
      .lin_quo (lin_quo),
      .ang_quo (ang_quo),
      .tag_out (tag_div)
   );

   // ---- duty mixing
   twdm_mix u_mix (
      .clock        (clock),
      .en           (en[PIPE_STAGES-1:DIV_STAGES+1]),
      .lin_quo      (lin_quo),
      .ang_quo      (ang_quo),
      .tag_in       (tag_div),
      .cfg          (cfg),
      .left_duty    (rsp_left_duty),
      .right_duty   (rsp_right_duty),
      .motion_kind  (rsp_motion_kind),
      .max_adjusted (rsp_max_adjusted)
   );

   // ---- assertions
   a_stop_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_motion_kind == KIND_STOP |-> rsp_left_duty == '0 && rsp_right_duty == '0)
      else $error("stop item with nonzero duty");

   a_adj_combined : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_max_adjusted |->
         rsp_motion_kind == KIND_FWD_LEFT || rsp_motion_kind == KIND_FWD_RIGHT ||
         rsp_motion_kind == KIND_BACK_LEFT || rsp_motion_kind == KIND_BACK_RIGHT)
      else $error("max readjust flagged outside combined motion");

   a_straight_equal : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_motion_kind == KIND_FWD || rsp_motion_kind == KIND_BACK) |->
         rsp_left_duty == rsp_right_duty)
      else $error("straight motion with unequal wheel duties");

   a_stall_full : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> valid_ff[0] && rsp_valid && rsp_stall)
      else $error("input stalled while the pipeline has room");

endmodule

/* rtl/core/twdm_div.sv */
// ----------------------------------------------------------------------------
// twdm_div
// Two-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module twdm_div (
   input  logic                            clock,
   input  logic [twdm_pkg::DIV_STAGES-1:0] en,
   input  logic [twdm_pkg::NUM_W-1:0]      lin_num,
   input  logic [twdm_pkg::DEN_W-1:0]      lin_den,
   input  logic [twdm_pkg::NUM_W-1:0]      ang_num,
   input  logic [twdm_pkg::DEN_W-1:0]      ang_den,
   input  twdm_pkg::twdm_tag_type          tag_in,
   output logic [twdm_pkg::QUO_W-1:0]      lin_quo,
   output logic [twdm_pkg::QUO_W-1:0]      ang_quo,
   output twdm_pkg::twdm_tag_type          tag_out
);
   import twdm_pkg::*;

   // One restoring step: shift in the next numerator bit, subtract if it fits
   function automatic twdm_lane_type div_step(input twdm_lane_type a);
      logic [DEN_W:0] r;
      logic [DEN_W:0] sub;
      twdm_lane_type  o;
      r     = {a.rem, a.num[NUM_W-1]};
      sub   = r - {1'b0, a.den};
      o     = a;
      o.num = {a.num[NUM_W-2:0], 1'b0};
      if (r >= {1'b0, a.den}) begin
         o.rem = sub[DEN_W-1:0];
         o.quo = {a.quo[QUO_W-2:0], 1'b1};
      end else begin
         o.rem = r[DEN_W-1:0];
         o.quo = {a.quo[QUO_W-2:0], 1'b0};
      end
      return o;
   endfunction

   twdm_div_stage_type stage_ff [DIV_STAGES];
   twdm_div_stage_type head;

   // Fresh item: remainder and quotient start at zero
   always_comb begin
      head.lin = '{rem: '0, num: lin_num, den: lin_den, quo: '0};
      head.ang = '{rem: '0, num: ang_num, den: ang_den, quo: '0};
      head.tag = tag_in;
   end

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      twdm_div_stage_type prev;
      twdm_div_stage_type stage_in;

      // Source of this stage: the operands or the previous stage
      if (k == 0) begin : g_first
         assign prev = head;
      end else begin : g_next
         assign prev = stage_ff[k-1];
      end

      always_comb begin
         stage_in.lin = div_step(prev.lin);
         stage_in.ang = div_step(prev.ang);
         stage_in.tag = prev.tag;
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            stage_ff[k] <= stage_in;
         end
      end
   end

   assign lin_quo = stage_ff[DIV_STAGES-1].lin.quo;
   assign ang_quo = stage_ff[DIV_STAGES-1].ang.quo;
   assign tag_out = stage_ff[DIV_STAGES-1].tag;

endmodule

/* rtl/core/twdm_mix.sv */
// ----------------------------------------------------------------------------
// twdm_mix
// Signs the step counts, scales them by the duty step, clamps and mixes the
// wheel duties; the last stage is the result register.
// ----------------------------------------------------------------------------
module twdm_mix (
   input  logic                            clock,
   input  logic [twdm_pkg::MIX_STAGES-1:0] en,
   input  logic [twdm_pkg::QUO_W-1:0]      lin_quo,
   input  logic [twdm_pkg::QUO_W-1:0]      ang_quo,
   input  twdm_pkg::twdm_tag_type          tag_in,
   input  twdm_pkg::twdm_cfg_type          cfg,
   output logic signed [10:0]              left_duty,
   output logic signed [10:0]              right_duty,
   output logic [3:0]                      motion_kind,
   output logic                            max_adjusted
);
   import twdm_pkg::*;

   // ---- stage 1: signed step counts and their sum
   logic signed [QUO_W:0]   sl_in, sa_in, sl_ff, sa_ff;
   logic signed [QUO_W+1:0] ssum_in, ssum_ff;
   twdm_tag_type            tag1_ff;

   always_comb begin
      sl_in   = tag_in.lin_nneg ? ((QUO_W+1)'(0) - {1'b0, lin_quo}) : {1'b0, lin_quo};
      sa_in   = tag_in.ang_nneg ? ((QUO_W+1)'(0) - {1'b0, ang_quo}) : {1'b0, ang_quo};
      ssum_in = {sl_in[QUO_W], sl_in} + {sa_in[QUO_W], sa_in};
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         sl_ff   <= sl_in;
         sa_ff   <= sa_in;
         ssum_ff <= ssum_in;
         tag1_ff <= tag_in;
      end
   end

   // ---- stage 2: scale by duty step
   logic signed [10:0] ds_x;
   logic signed [29:0] p_lin_in, p_ang_in, p_sum_in;
   logic signed [29:0] p_lin_ff, p_ang_ff, p_sum_ff;
   twdm_tag_type       tag2_ff;

   always_comb begin
      ds_x     = $signed({1'b0, cfg.duty_step});
      p_lin_in = 30'(sl_ff) * 30'(ds_x);
      p_ang_in = 30'(sa_ff) * 30'(ds_x);
      p_sum_in = 30'(ssum_ff) * 30'(ds_x);
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         p_lin_ff <= p_lin_in;
         p_ang_ff <= p_ang_in;
         p_sum_ff <= p_sum_in;
         tag2_ff  <= tag1_ff;
      end
   end

   // ---- stage 3: clamped candidates and turn difference
   logic signed [30:0] bd_x, btd_x, diff_full;
   logic [9:0]         d_lin_in, d_ang_in, slow_in;
   logic [9:0]         d_lin_ff, d_ang_ff, slow_ff;
   logic [29:0]        diff_in, diff_ff;
   twdm_tag_type       tag3_ff;

   always_comb begin
      bd_x      = 31'($signed({1'b0, cfg.base_duty}));
      btd_x     = 31'($signed({1'b0, cfg.base_turn_diff}));
      d_lin_in  = twdm_clamp(bd_x + 31'(p_lin_ff), cfg.max_duty, cfg.min_duty);
      d_ang_in  = twdm_clamp(bd_x + 31'(p_ang_ff), cfg.max_duty, cfg.min_duty);
      slow_in   = twdm_clamp(bd_x + 31'(p_sum_ff), cfg.max_duty, cfg.min_duty);
      diff_full = btd_x + 31'(p_ang_ff);
      diff_in   = diff_full[30] ? '0 : diff_full[29:0];
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         d_lin_ff <= d_lin_in;
         d_ang_ff <= d_ang_in;
         slow_ff  <= slow_in;
         diff_ff  <= diff_in;
         tag3_ff  <= tag2_ff;
      end
   end

   // ---- stage 4: readjust at max, place wheels, apply direction
   twdm_kind_type      kind;
   logic [30:0]        fast_sum, min_sum;
   logic [29:0]        max_less;
   logic               over;
   logic [9:0]         slow_v, fast_v, l_mag, r_mag;
   logic               l_neg, r_neg, adj;
   logic signed [10:0] left_in, right_in;
   logic signed [10:0] left_ff, right_ff;
   logic [3:0]         kind_ff;
   logic               adj_ff;

   always_comb begin
      // motion kind from the signs of the command
      if (tag3_ff.lin_zero && tag3_ff.ang_zero) begin
         kind = KIND_STOP;
      end else if (tag3_ff.ang_zero) begin
         kind = tag3_ff.lin_neg ? KIND_BACK : KIND_FWD;
      end else if (tag3_ff.lin_zero) begin
         kind = tag3_ff.ang_neg ? KIND_RIGHT : KIND_LEFT;
      end else if (!tag3_ff.lin_neg) begin
         kind = tag3_ff.ang_neg ? KIND_FWD_RIGHT : KIND_FWD_LEFT;
      end else begin
         kind = tag3_ff.ang_neg ? KIND_BACK_LEFT : KIND_BACK_RIGHT;
      end

      // fast wheel over max: pin it and pull the slow one down
      fast_sum = 31'(slow_ff) + 31'(diff_ff);
      min_sum  = 31'(cfg.min_duty) + 31'(diff_ff);
      max_less = 30'(cfg.max_duty) - diff_ff;
      over     = fast_sum > 31'(cfg.max_duty);
      if (over) begin
         fast_v = cfg.max_duty;
         slow_v = (min_sum > 31'(cfg.max_duty)) ? cfg.min_duty : max_less[9:0];
      end else begin
         fast_v = fast_sum[9:0];
         slow_v = slow_ff;
      end

      l_mag = '0;
      r_mag = '0;
      l_neg = 1'b0;
      r_neg = 1'b0;
      adj   = 1'b0;
      case (kind)
         KIND_STOP: begin
         end
         KIND_FWD, KIND_BACK: begin
            l_mag = d_lin_ff;
            r_mag = d_lin_ff;
            l_neg = tag3_ff.lin_neg;
            r_neg = tag3_ff.lin_neg;
         end
         KIND_LEFT: begin
            r_mag = d_ang_ff;
         end
         KIND_RIGHT: begin
            l_mag = d_ang_ff;
         end
         KIND_FWD_LEFT, KIND_BACK_LEFT: begin
            // right wheel is the fast one
            l_mag = slow_v;
            r_mag = fast_v;
            l_neg = tag3_ff.lin_neg;
            r_neg = tag3_ff.lin_neg;
            adj   = over;
         end
         KIND_FWD_RIGHT, KIND_BACK_RIGHT: begin
            l_mag = fast_v;
            r_mag = slow_v;
            l_neg = tag3_ff.lin_neg;
            r_neg = tag3_ff.lin_neg;
            adj   = over;
         end
         default: begin
         end
      endcase

      left_in  = l_neg ? (11'sd0 - $signed({1'b0, l_mag})) : $signed({1'b0, l_mag});
      right_in = r_neg ? (11'sd0 - $signed({1'b0, r_mag})) : $signed({1'b0, r_mag});
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         left_ff  <= left_in;
         right_ff <= right_in;
         kind_ff  <= kind;
         adj_ff   <= adj;
      end
   end

   assign left_duty    = left_ff;
   assign right_duty   = right_ff;
   assign motion_kind  = kind_ff;
   assign max_adjusted = adj_ff;

endmodule

/* tb/twist_to_wheel_duty_mixer_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twist_to_wheel_duty_mixer_unit_tb
// Self-checking bench for the duty mixer. Speed commands go in on the req
// channel under random gaps and the wheel duties come back on the rsp
// channel under random stalls. A scoreboard recomputes every item in
// integer thousandths and checks the results in order. The run steps
// through several register settings, including the range extremes, a
// zero speed step, masked wide writes and min duty above max duty. One
// long receiver stall fills the pipeline so that the input stalls.
// ----------------------------------------------------------------------------
module twist_to_wheel_duty_mixer_unit_tb;
   import twdm_pkg::*;

   localparam logic [2:0]         CSR_UNUSED_INDEX = 3'd7;
   localparam logic signed [15:0] SPEED_MAX        = 16'sh7FFF;
   localparam logic signed [15:0] SPEED_MIN        = 16'sh8000;
   localparam int                 MAX_IDLE         = 16;
   localparam int                 CHOKE_CYCLES     = 300;
   localparam int                 SETTLE_CYCLES    = 30;
   localparam int                 DRAIN_LIMIT      = 20000;
   localparam int                 MAX_REPORTS      = 10;

   // One wheel result as the block should return it
   typedef struct {
      logic signed [10:0] left_duty;
      logic signed [10:0] right_duty;
      twdm_kind_type      kind;
      logic               adjusted;
   } wheel_duty_type;

   // Register mirror, duty predictor and in-order result check
   class wheel_duty_scoreboard;
      int             base_speed;
      int             speed_step;
      int             base_duty;
      int             duty_step;
      int             max_duty;
      int             min_duty;
      int             base_turn_diff;
      wheel_duty_type predicted_duties[$];
      int             errors;

      function new();
         errors         = 0;
         base_speed     = int'(RST_BASE_SPEED);
         speed_step     = int'(RST_SPEED_STEP);
         base_duty      = int'(RST_BASE_DUTY);
         duty_step      = int'(RST_DUTY_STEP);
         max_duty       = int'(RST_MAX_DUTY);
         min_duty       = int'(RST_MIN_DUTY);
         base_turn_diff = int'(RST_BASE_TURN_DIFF);
      endfunction

      function void write_reg(logic [2:0] idx, logic [14:0] v);
         case (idx)
            CSR_BASE_SPEED:     base_speed     = int'(v);
            CSR_SPEED_STEP:     speed_step     = int'(v);
            CSR_BASE_DUTY:      base_duty      = int'(v[9:0]);
            CSR_DUTY_STEP:      duty_step      = int'(v[9:0]);
            CSR_MAX_DUTY:       max_duty       = int'(v[9:0]);
            CSR_MIN_DUTY:       min_duty       = int'(v[9:0]);
            CSR_BASE_TURN_DIFF: base_turn_diff = int'(v[9:0]);
            default: ;
         endcase
      endfunction

      // Steps away from base speed, rounded half away from zero
      function longint speed_steps(longint v);
         longint mag, n, d, m, q;
         mag = (v < 0) ? -v : v;
         n   = mag - longint'(base_speed);
         d   = (speed_step == 0) ? 1 : longint'(speed_step);
         m   = (n < 0) ? -n : n;
         q   = (2 * m + d) / (2 * d);
         return (n < 0) ? -q : q;
      endfunction

      // Upper clamp first, then the lower one wins
      function longint clamp_duty(longint x);
         if (x > longint'(max_duty)) x = longint'(max_duty);
         if (x < longint'(min_duty)) x = longint'(min_duty);
         return x;
      endfunction

      function void note_command(logic signed [15:0] lin, logic signed [15:0] ang);
         longint         l, a, sl, sa, ds, d, slow, fast, diff, dl, dr;
         bit             right_fast;
         wheel_duty_type e;
         l  = lin;
         a  = ang;
         sl = speed_steps(l);
         sa = speed_steps(a);
         ds = longint'(duty_step);
         dl = 0;
         dr = 0;
         e.adjusted = 1'b0;
         if (l == 0 && a == 0) begin
            e.kind = KIND_STOP;
         end else if (a == 0) begin
            d      = clamp_duty(longint'(base_duty) + sl * ds);
            e.kind = (l > 0) ? KIND_FWD : KIND_BACK;
            dl     = (l > 0) ? d : -d;
            dr     = dl;
         end else if (l == 0) begin
            d = clamp_duty(longint'(base_duty) + sa * ds);
            if (a > 0) begin
               e.kind = KIND_LEFT;
               dr     = d;
            end else begin
               e.kind = KIND_RIGHT;
               dl     = d;
            end
         end else begin
            // combined motion: faster wheel gets the turn difference on top
            slow = clamp_duty(longint'(base_duty) + (sl + sa) * ds);
            diff = longint'(base_turn_diff) + sa * ds;
            if (diff < 0) diff = 0;
            fast = slow + diff;
            if (fast > longint'(max_duty)) begin
               fast = longint'(max_duty);
               slow = fast - diff;
               if (slow < longint'(min_duty)) slow = longint'(min_duty);
               e.adjusted = 1'b1;
            end
            right_fast = ((l > 0) == (a > 0));
            dl = right_fast ? slow : fast;
            dr = right_fast ? fast : slow;
            if (l < 0) begin
               dl = -dl;
               dr = -dr;
            end
            if (l > 0) e.kind = (a > 0) ? KIND_FWD_LEFT : KIND_FWD_RIGHT;
            else       e.kind = (a < 0) ? KIND_BACK_LEFT : KIND_BACK_RIGHT;
         end
         e.left_duty  = dl[10:0];
         e.right_duty = dr[10:0];
         predicted_duties.push_back(e);
      endfunction

      function void check_result(logic signed [10:0] left, logic signed [10:0] right,
                                 logic [3:0] kind, logic adj);
         wheel_duty_type e;
         if (predicted_duties.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("unexpected item: left %0d right %0d kind %0d adj %0b",
                        left, right, kind, adj);
            return;
         end
         e = predicted_duties.pop_front();
         if (left !== e.left_duty || right !== e.right_duty ||
             kind !== e.kind || adj !== e.adjusted) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display({"mismatch: expected left %0d right %0d kind %0d adj %0b,",
                         " got left %0d right %0d kind %0d adj %0b"},
                        e.left_duty, e.right_duty, e.kind, e.adjusted,
                        left, right, kind, adj);
         end
      endfunction

      function int outstanding();
         return predicted_duties.size();
      endfunction
   endclass

   logic               clock             = 1'b0;
   logic               reset             = 1'b1;
   logic               req_valid         = 1'b0;
   logic               req_stall;
   logic signed [15:0] req_linear_speed  = '0;
   logic signed [15:0] req_angular_speed = '0;
   logic               rsp_valid;
   logic               rsp_stall         = 1'b0;
   logic signed [10:0] rsp_left_duty;
   logic signed [10:0] rsp_right_duty;
   logic [3:0]         rsp_motion_kind;
   logic               rsp_max_adjusted;
   logic               csr_write_enable  = 1'b0;
   logic [2:0]         csr_index         = '0;
   logic [14:0]        csr_data          = '0;

   wheel_duty_scoreboard sb = new();
   bit                   tx_burst = 1'b0;
   bit                   rx_burst = 1'b0;
   bit                   choke    = 1'b0;

   twist_to_wheel_duty_mixer_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_linear_speed  (req_linear_speed),
      .req_angular_speed (req_angular_speed),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_left_duty     (rsp_left_duty),
      .rsp_right_duty    (rsp_right_duty),
      .rsp_motion_kind   (rsp_motion_kind),
      .rsp_max_adjusted  (rsp_max_adjusted),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #5 clock = ~clock;

   // Check every item the block hands over
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_left_duty, rsp_right_duty, rsp_motion_kind, rsp_max_adjusted);
   end

   // Offer one command after a random gap, hold it until taken
   task automatic send_command(input logic signed [15:0] lin,
                               input logic signed [15:0] ang);
      int gap;
      gap = tx_burst ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_linear_speed  <= lin;
      req_angular_speed <= ang;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_command(lin, ang);
   endtask

   // Stop offering and let every pending result come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   task automatic cfg_write(input logic [2:0] idx, input logic [14:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_data         <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   task automatic apply_settings(input logic [14:0] bs, input logic [14:0] ss,
                                 input logic [14:0] bd, input logic [14:0] dst,
                                 input logic [14:0] mx, input logic [14:0] mn,
                                 input logic [14:0] td);
      wait_idle();
      cfg_write(CSR_BASE_SPEED, bs);
      cfg_write(CSR_SPEED_STEP, ss);
      cfg_write(CSR_BASE_DUTY, bd);
      cfg_write(CSR_DUTY_STEP, dst);
      cfg_write(CSR_MAX_DUTY, mx);
      cfg_write(CSR_MIN_DUTY, mn);
      cfg_write(CSR_BASE_TURN_DIFF, td);
      // writes past the register list must leave everything alone
      cfg_write(CSR_UNUSED_INDEX, 15'($urandom));
      csr_write_enable <= 1'b0;
   endtask

   // Mostly in-range values, now and then anything the width allows
   function automatic logic [14:0] rand_reg(input int lo, input int hi);
      if ($urandom_range(0, 3) == 0) return 15'($urandom);
      return 15'($urandom_range(lo, hi));
   endfunction

   task automatic random_settings();
      apply_settings(rand_reg(0, 3000), rand_reg(1, 1000), rand_reg(0, 1000),
                     rand_reg(0, 200), rand_reg(0, 1000), rand_reg(0, 1000),
                     rand_reg(0, 1000));
   endtask

   // Speeds weighted toward zero, the extremes and rounding ties
   function automatic logic signed [15:0] rand_speed();
      int                 step;
      int                 off;
      logic signed [15:0] v;
      step = (sb.speed_step == 0) ? 1 : sb.speed_step;
      case ($urandom_range(0, 11))
         0:       v = '0;
         1:       v = SPEED_MAX;
         2:       v = SPEED_MIN;
         3, 4:    v = 16'($urandom);
         5, 6, 7: begin
            off = sb.base_speed + (int'($urandom_range(0, 8)) - 4) * step
                  + (step / 2) * int'($urandom_range(0, 1)) + int'($urandom_range(0, 2)) - 1;
            v = 16'(off);
            if ($urandom_range(0, 1)) v = -v;
         end
         default: begin
            v = 16'($urandom_range(0, 4000));
            if ($urandom_range(0, 1)) v = -v;
         end
      endcase
      return v;
   endfunction

   task automatic run_random(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) tx_burst = ($urandom_range(0, 3) == 0);
         send_command(rand_speed(), rand_speed());
      end
      tx_burst = 1'b0;
   endtask

   // Extremes, each motion kind, rounding ties and the max readjustment
   task automatic run_directed();
      send_command(16'sd0, 16'sd0);
      send_command(SPEED_MAX, 16'sd0);
      send_command(SPEED_MIN, 16'sd0);
      send_command(16'sd0, SPEED_MAX);
      send_command(16'sd0, SPEED_MIN);
      send_command(SPEED_MAX, SPEED_MAX);
      send_command(SPEED_MAX, SPEED_MIN);
      send_command(SPEED_MIN, SPEED_MIN);
      send_command(SPEED_MIN, SPEED_MAX);
      send_command(16'sd650, 16'sd0);
      send_command(16'sd550, 16'sd0);
      send_command(-16'sd650, 16'sd0);
      send_command(16'sd0, -16'sd550);
      send_command(16'sd1, 16'sd1);
      send_command(16'sd1, -16'sd1);
      send_command(-16'sd1, -16'sd1);
      send_command(-16'sd1, 16'sd1);
      send_command(16'sd1500, 16'sd1500);
      send_command(-16'sd1500, 16'sd1500);
      send_command(16'sd1000, 16'sd1);
      send_command(-16'sd1000, -16'sd1);
      send_command(16'sd600, 16'sd600);
   endtask

   // Receiver: random holds, bursts without holds, one long choke
   initial begin
      int hold;
      int served;
      served = 0;
      while (reset) @(posedge clock);
      forever begin
         if (choke) begin
            choke = 1'b0;
            rsp_stall <= 1'b1;
            for (int c = 0; c < CHOKE_CYCLES; c++) @(posedge clock);
         end else begin
            hold = rx_burst ? 0 : $urandom_range(0, MAX_IDLE);
            if (hold > 0) begin
               rsp_stall <= 1'b1;
               repeat (hold) @(posedge clock);
            end
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         served++;
         if (served % 40 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      end
   end

   initial begin
      int drain;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset defaults
      run_directed();
      run_random(150);

      // everything at the low end
      apply_settings(15'd0, 15'd1, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0);
      run_random(90);

      // top of the stated ranges
      apply_settings(15'd32767, 15'd32767, 15'd1000, 15'd1000, 15'd1000, 15'd1000,
                     15'd1000);
      run_random(90);

      // full width, zero speed step, upper data bits masked off
      apply_settings(15'h7FFF, 15'd0, 15'h7FFF, 15'd1023, 15'h43FF, 15'd0, 15'd1023);
      run_random(90);

      // min duty above max duty
      apply_settings(15'd600, 15'd50, 15'd500, 15'd40, 15'd300, 15'd900, 15'd150);
      run_random(100);

      // receiver chokes while the sender keeps going back to back
      random_settings();
      choke    = 1'b1;
      tx_burst = 1'b1;
      for (int i = 0; i < 80; i++) send_command(rand_speed(), rand_speed());
      tx_burst = 1'b0;
      run_random(50);

      for (int p = 0; p < 3; p++) begin
         random_settings();
         run_random(100);
      end

      req_valid <= 1'b0;
      drain = 0;
      while (sb.outstanding() != 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.outstanding() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // Hang guard
   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

/* twist_to_wheel_duty_mixer_unit.f */
rtl/core/twdm_pkg.sv
rtl/core/twdm_div.sv
rtl/core/twdm_mix.sv
rtl/core/twist_to_wheel_duty_mixer_unit.sv
tb/twist_to_wheel_duty_mixer_unit_tb.sv
